FILE: rtl/dfam_pkg.sv
// dfam_pkg: shared types and codes of the table-driven dfa matcher
// no dependencies; used by every module of the block
package dfam_pkg;

  localparam int unsigned StateW  = 6;
  localparam int unsigned SymbolW = 8;
  localparam int unsigned EntryW  = 7;
  localparam int unsigned WordW   = 64;

  // transition entry: live bit above the 6-bit target
  localparam int unsigned EntryLiveBit = 6;
  localparam logic [EntryW-1:0] EntryDead = 7'b000_0000;

  // the one command code with no operation behind it
  localparam logic [2:0] CmdUnknown = 3'd7;

  typedef enum logic [2:0] {
    CMD_STEP        = 3'd0,
    CMD_RESTART     = 3'd1,
    CMD_ADD_STATE   = 3'd2,
    CMD_ADD_TRANS   = 3'd3,
    CMD_SET_ACCEPT  = 3'd4,
    CMD_QUERY_CUR   = 3'd5,
    CMD_QUERY_NAMED = 3'd6
  } dfam_cmd_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_BAD     = 2'd1,
    STATUS_FULL    = 2'd2
  } dfam_status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_STEP_WAIT,
    ST_TR_WAIT,
    ST_ACC_RD,
    ST_EMIT
  } dfam_state_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [SymbolW-1:0] symbol;
    logic [StateW-1:0]  from_state;
    logic [StateW-1:0]  to_state;
    logic               to_dead;
  } dfam_in_t;

  typedef struct packed {
    logic [StateW-1:0] current_state;
    logic              is_dead;
    logic              accepting;
    logic [WordW-1:0]  mask_word;
    logic [1:0]        word_index;
    logic              last;
    logic [1:0]        status;
  } dfam_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic exec;
    logic step_rd;
    logic step_upd;
    logic tr_write;
    logic tr_update;
    logic acc_rd;
    logic q_rd;
    logic q_first;
  } dfam_ctl_t;

  // datapath to controller
  typedef struct packed {
    dfam_cmd_e command;
    logic      cmd_known;
    logic      dead;
    logic      tr_ok;
    logic      is_query;
    logic      last;
    logic      sweep_done;
  } dfam_sts_t;

endpackage

FILE: rtl/table_driven_dfa_matcher_top.sv
// table_driven_dfa_matcher_top: loadable dfa matcher, controller plus datapath
// depends on dfam_pkg, dfam_ctrl, dfam_datapath
//
//  channel   ports                          direction  transfer
//  command   start_i, busy_o, cmd_i         in         start_i high while busy_o low
//  result    result_strobe_o, result_o      out        every cycle result_strobe_o is high
//
// each command passes exec, accepting read and emit, plus a wait state for some:
//   restart, add state, set accepting, unknown code, dead step, rejected write: none
//   live step, accepted transition write: store read or mask read-modify-write
//   query current or named: four result words on consecutive cycles
// after reset the block clears all stores, with busy_o high
// results cannot be held off: each word is valid for exactly one cycle
module table_driven_dfa_matcher_top #(
  parameter int unsigned NUM_STATES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  dfam_pkg::dfam_in_t  cmd_i,
  output logic                result_strobe_o,
  output dfam_pkg::dfam_out_t result_o
);

  // command and status between the sequencer and the datapath
  dfam_pkg::dfam_ctl_t ctl;
  dfam_pkg::dfam_sts_t sts;

  // sequencer: clearing pass, command execution, result emission
  dfam_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .sts_i    (sts),
    .ctl_o    (ctl),
    .busy_o   (busy_o),
    .strobe_o (result_strobe_o)
  );

  // stores and state registers
  dfam_datapath #(
    .NUM_STATES (NUM_STATES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .res_o  (result_o)
  );

endmodule

FILE: rtl/dfam_ctrl.sv
// dfam_ctrl: sequencing state machine of the dfa matcher
// depends on dfam_pkg (state enum, command and status structs)
module dfam_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  dfam_pkg::dfam_sts_t sts_i,
  output dfam_pkg::dfam_ctl_t ctl_o,
  output logic                busy_o,
  output logic                strobe_o
);

  dfam_pkg::dfam_state_e state_d, state_q;
  logic is_step, is_trans;

  assign is_step  = sts_i.cmd_known && (sts_i.command == dfam_pkg::CMD_STEP);
  assign is_trans = sts_i.cmd_known && (sts_i.command == dfam_pkg::CMD_ADD_TRANS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfam_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dfam_pkg::ST_CLEAR: begin
        if (sts_i.sweep_done) state_d = dfam_pkg::ST_IDLE;
      end
      dfam_pkg::ST_IDLE: begin
        if (start_i) state_d = dfam_pkg::ST_EXEC;
      end
      dfam_pkg::ST_EXEC: begin
        if (is_step && !sts_i.dead) begin
          state_d = dfam_pkg::ST_STEP_WAIT;
        end else if (is_trans && sts_i.tr_ok) begin
          state_d = dfam_pkg::ST_TR_WAIT;
        end else begin
          state_d = dfam_pkg::ST_ACC_RD;
        end
      end
      dfam_pkg::ST_STEP_WAIT: state_d = dfam_pkg::ST_ACC_RD;
      dfam_pkg::ST_TR_WAIT:   state_d = dfam_pkg::ST_ACC_RD;
      dfam_pkg::ST_ACC_RD:    state_d = dfam_pkg::ST_EMIT;
      dfam_pkg::ST_EMIT: begin
        if (sts_i.last) state_d = dfam_pkg::ST_IDLE;
      end
      default: state_d = dfam_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o    = '0;
    busy_o   = 1'b1;
    strobe_o = 1'b0;
    unique case (state_q)
      dfam_pkg::ST_CLEAR: ctl_o.clear = 1'b1;
      dfam_pkg::ST_IDLE: begin
        busy_o        = 1'b0;
        ctl_o.capture = start_i;
      end
      dfam_pkg::ST_EXEC: begin
        ctl_o.exec     = 1'b1;
        ctl_o.step_rd  = is_step && !sts_i.dead;
        ctl_o.tr_write = is_trans && sts_i.tr_ok;
      end
      dfam_pkg::ST_STEP_WAIT: ctl_o.step_upd = 1'b1;
      dfam_pkg::ST_TR_WAIT:   ctl_o.tr_update = 1'b1;
      dfam_pkg::ST_ACC_RD: begin
        ctl_o.acc_rd  = 1'b1;
        ctl_o.q_rd    = sts_i.is_query;
        ctl_o.q_first = 1'b1;
      end
      dfam_pkg::ST_EMIT: begin
        strobe_o   = 1'b1;
        ctl_o.q_rd = sts_i.is_query && !sts_i.last;
      end
      default: busy_o = 1'b1;
    endcase
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dfam_pkg::ST_IDLE && start_i) |=> state_q == dfam_pkg::ST_EXEC)
    else $error("accepted transfer did not enter exec");

  a_query_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !sts_i.last) |=> strobe_o)
    else $error("query result burst broken before last word");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != dfam_pkg::ST_CLEAR) |=> state_q != dfam_pkg::ST_CLEAR)
    else $error("clearing pass re-entered outside reset");

endmodule

FILE: rtl/dfam_datapath.sv
// dfam_datapath: transition store, byte mask store, accepting store and state registers
// depends on dfam_pkg (payload and command/status structs)
module dfam_datapath #(
  parameter int unsigned NUM_STATES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dfam_pkg::dfam_in_t   in_i,
  input  dfam_pkg::dfam_ctl_t  ctl_i,
  output dfam_pkg::dfam_sts_t  sts_o,
  output dfam_pkg::dfam_out_t  res_o
);

  localparam int unsigned SW     = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int unsigned AW     = SW + 8;
  localparam int unsigned CW     = $clog2(NUM_STATES + 1);
  localparam int unsigned CMPW   = (CW > dfam_pkg::StateW) ? CW : dfam_pkg::StateW;
  localparam int unsigned SXW    = (SW > dfam_pkg::StateW) ? SW : dfam_pkg::StateW;
  localparam int unsigned TDepth = NUM_STATES * 256;
  localparam int unsigned VDepth = NUM_STATES * 4;

  logic [dfam_pkg::EntryW-1:0] trans_mem [TDepth];
  logic [dfam_pkg::WordW-1:0]  vmap_mem  [VDepth];
  logic                        acc_mem   [NUM_STATES];

  dfam_pkg::dfam_in_t          in_q;
  logic [dfam_pkg::StateW-1:0] ps_q, qs_q, qs_d;
  logic                        dead_q, qzero_q, qzero_d;
  logic [CW-1:0]               count_q;
  logic [1:0]                  status_q, status_d, word_q, rd_word;
  logic [AW-1:0]               clr_q;
  logic [dfam_pkg::EntryW-1:0] trd_q;
  logic [dfam_pkg::WordW-1:0]  vrd_q, bit_mask;
  logic                        accrd_q;

  logic [CMPW-1:0] from_x, to_x, count_x, nst_x;
  logic            from_in_range, from_used, tr_ok, cmd_known, is_query;
  logic [SW-1:0]   from_idx, ps_idx, qs_idx;
  dfam_pkg::dfam_cmd_e cmd;

  assign cmd       = dfam_pkg::dfam_cmd_e'(in_q.command);
  assign cmd_known = (in_q.command != dfam_pkg::CmdUnknown);
  assign is_query  = cmd_known &&
                     ((cmd == dfam_pkg::CMD_QUERY_CUR) || (cmd == dfam_pkg::CMD_QUERY_NAMED));

  assign from_x  = CMPW'(in_q.from_state);
  assign to_x    = CMPW'(in_q.to_state);
  assign count_x = CMPW'(count_q);
  assign nst_x   = CMPW'(NUM_STATES);

  assign from_in_range = from_x < nst_x;
  assign from_used     = from_x < count_x;
  assign tr_ok         = from_used && (in_q.to_dead || (to_x < nst_x));

  // state numbers are cut to the store index width; writes use them only once known to be in range
  assign from_idx = SW'(SXW'(in_q.from_state));
  assign ps_idx   = SW'(SXW'(ps_q));
  assign qs_idx   = SW'(SXW'(qs_q));

  assign rd_word  = ctl_i.q_first ? 2'd0 : word_q + 2'd1;
  assign bit_mask = dfam_pkg::WordW'(1) << in_q.symbol[5:0];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q    <= '0;
      dead_q  <= 1'b0;
      count_q <= CW'(1);
      clr_q   <= '0;
    end else begin
      if (ctl_i.clear) clr_q <= clr_q + AW'(1);
      if (ctl_i.exec) begin
        if (cmd_known && cmd == dfam_pkg::CMD_RESTART) begin
          ps_q   <= '0;
          dead_q <= 1'b0;
        end
        if (cmd_known && cmd == dfam_pkg::CMD_ADD_STATE && count_x < nst_x) begin
          count_q <= count_q + CW'(1);
        end
      end
      if (ctl_i.step_upd) begin
        if (trd_q[dfam_pkg::EntryLiveBit]) begin
          ps_q <= trd_q[dfam_pkg::StateW-1:0];
        end else begin
          ps_q   <= '0;
          dead_q <= 1'b1;
        end
      end
    end
  end

  // per-command status and query source
  always_comb begin
    status_d = dfam_pkg::STATUS_DONE;
    qs_d     = ps_q;
    qzero_d  = dead_q;
    if (cmd_known) begin
      case (cmd)
        dfam_pkg::CMD_ADD_STATE: begin
          if (!(count_x < nst_x)) status_d = dfam_pkg::STATUS_FULL;
        end
        dfam_pkg::CMD_ADD_TRANS: begin
          if (!tr_ok) status_d = dfam_pkg::STATUS_BAD;
        end
        dfam_pkg::CMD_SET_ACCEPT: begin
          if (!from_in_range) status_d = dfam_pkg::STATUS_BAD;
        end
        dfam_pkg::CMD_QUERY_NAMED: begin
          qs_d    = in_q.from_state;
          qzero_d = !from_used;
          if (!from_used) status_d = dfam_pkg::STATUS_BAD;
        end
        default: ;
      endcase
    end
  end

  // payload and per-command registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) in_q <= in_i;
    if (ctl_i.exec) begin
      word_q   <= 2'd0;
      status_q <= status_d;
      qs_q     <= qs_d;
      qzero_q  <= qzero_d;
    end
    if (ctl_i.q_rd) word_q <= rd_word;
  end

  // transition store
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      trans_mem[clr_q] <= dfam_pkg::EntryDead;
    end else if (ctl_i.tr_write) begin
      trans_mem[{from_idx, in_q.symbol}] <= in_q.to_dead ? dfam_pkg::EntryDead :
                                            {1'b1, in_q.to_state};
    end
    if (ctl_i.step_rd) trd_q <= trans_mem[{ps_idx, in_q.symbol}];
  end

  // valid byte mask store, read-modify-write on transition writes
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      vmap_mem[clr_q[AW-1:6]] <= '0;
    end else if (ctl_i.tr_update) begin
      vmap_mem[{from_idx, in_q.symbol[7:6]}] <= in_q.to_dead ? (vrd_q & ~bit_mask) :
                                                (vrd_q | bit_mask);
    end
    if (ctl_i.tr_write) begin
      vrd_q <= vmap_mem[{from_idx, in_q.symbol[7:6]}];
    end else if (ctl_i.q_rd) begin
      vrd_q <= vmap_mem[{qs_idx, rd_word}];
    end
  end

  // accepting store
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      acc_mem[clr_q[AW-1:8]] <= 1'b0;
    end else if (ctl_i.exec && cmd_known && cmd == dfam_pkg::CMD_SET_ACCEPT && from_in_range) begin
      acc_mem[from_idx] <= 1'b1;
    end
    if (ctl_i.acc_rd) accrd_q <= acc_mem[ps_idx];
  end

  assign sts_o.command    = cmd;
  assign sts_o.cmd_known  = cmd_known;
  assign sts_o.dead       = dead_q;
  assign sts_o.tr_ok      = tr_ok;
  assign sts_o.is_query   = is_query;
  assign sts_o.last       = !is_query || (word_q == 2'd3);
  assign sts_o.sweep_done = (clr_q == AW'(TDepth - 1));

  assign res_o.current_state = dead_q ? '0 : ps_q;
  assign res_o.is_dead       = dead_q;
  assign res_o.accepting     = !dead_q && accrd_q;
  assign res_o.mask_word     = (is_query && !qzero_q) ? vrd_q : '0;
  assign res_o.word_index    = word_q;
  assign res_o.last          = sts_o.last;
  assign res_o.status        = status_q;

endmodule
